### hw/rtl/ple_pkg.sv
// Shared types and constants of the lattice energy unit.
// Depends on nothing; every other file but ple_ram imports it.
package ple_pkg;

	localparam int SIDE_W         = 7;
	localparam int COUPLING_W     = 16;
	localparam int ENERGY_W       = 22;
	localparam int CFG_DATA_W     = 16;
	localparam int CFG_IDX_W      = 1;
	localparam int INCR_W         = 3;
	localparam int QUEUE_DEPTH    = 4;
	localparam int DEF_MAX_SIDE   = 64;
	localparam int DEF_SPIN_BITS  = 8;

	localparam logic [CFG_IDX_W-1:0] REG_SIDE_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUPLING    = 1'd1;

	localparam logic [SIDE_W-1:0]            SIDE_RESET     = 7'd3;
	localparam logic signed [COUPLING_W-1:0] COUPLING_RESET = 16'sd256;

	localparam logic [INCR_W-1:0] MAX_INCR = 3'd4;

	// One classified site: equal pairs found at it, and end-of-lattice mark.
	typedef struct packed {
		logic [INCR_W-1:0] incr;
		logic              last;
	} bond_t;

endpackage

### hw/rtl/potts_lattice_energy_unit.sv
// Top level of the Potts lattice energy unit: configuration registers,
// front end, pair queue and back end. Uses ple_pkg, ple_front, ple_queue, ple_back.
//
//  channel   handshake                 payload
//  -------   -----------------------   ---------------------------------
//  sites     push / full               spin [SPIN_BITS]
//  energy    empty / pop               lattice_energy [22], signed
//  config    cfg_we (no wait)          cfg_index [1], cfg_wdata [16]
//
// One site is taken every cycle while full is low; the front end's one-site
// stage and the back end stay in step through a four-entry pair queue.
// After its last site is taken, the energy of a lattice passes the RAM read,
// pair queue, sum, multiply and scale stages on its way to the result ports.
// Reset clears position, count and all valid flags; registers return to
// side 3 and coupling 1.0. The row buffers are not cleared.
// While a result waits unread, later sites keep flowing until the queue
// and the back end's stages fill; then full rises.
module potts_lattice_energy_unit #(
	parameter int MAX_SIDE  = ple_pkg::DEF_MAX_SIDE,
	parameter int SPIN_BITS = ple_pkg::DEF_SPIN_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [SPIN_BITS-1:0]                spin,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [ple_pkg::ENERGY_W-1:0] lattice_energy,
	input  logic                                cfg_we,
	input  logic [ple_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ple_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import ple_pkg::*;

	logic [SIDE_W-1:0]            side_length_q;
	logic signed [COUPLING_W-1:0] coupling_q;
	logic                         restart;

	logic  q_push, q_full, q_pop, q_empty;
	bond_t q_entry, q_head;

	// A side write restarts the lattice in both halves.
	assign restart = cfg_we && (cfg_index == REG_SIDE_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_length_q <= SIDE_RESET;
			coupling_q    <= COUPLING_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIDE_LENGTH: side_length_q <= cfg_wdata[SIDE_W-1:0];
				REG_COUPLING:    coupling_q    <= $signed(cfg_wdata[COUPLING_W-1:0]);
				default: ;
			endcase
		end
	end

	// Classify each site as it arrives.
	ple_front #(.MAX_SIDE(MAX_SIDE), .SPIN_BITS(SPIN_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.side_length (side_length_q),
		.restart     (restart),
		.push        (push),
		.full        (full),
		.spin        (spin),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_entry     (q_entry)
	);

	// Decouple classification from accumulation.
	ple_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_en (q_push),
		.din     (q_entry),
		.pop_en  (q_pop),
		.dout    (q_head),
		.full    (q_full),
		.empty   (q_empty)
	);

	// Accumulate, scale and hold the energy.
	ple_back #(.MAX_SIDE(MAX_SIDE)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.restart        (restart),
		.coupling       (coupling_q),
		.q_empty        (q_empty),
		.q_entry        (q_head),
		.q_pop          (q_pop),
		.empty          (empty),
		.pop            (pop),
		.lattice_energy (lattice_energy)
	);

	// The front end stalls only on a full pair queue.
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> q_full)
		else $error("site input stalled while pair queue had room");

	// The back end never takes from an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pair queue popped while empty");

	// A site has at most four equal pairs.
	a_incr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_entry.incr <= MAX_INCR))
		else $error("site reported more than four equal pairs");

endmodule

### hw/rtl/ple_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read-first: a read and a write of the same address return the old word.
module ple_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/ple_front.sv
// Front end: accepts sites, tracks raster position, keeps the row buffers
// and classifies each site into a count of equal pairs. Uses ple_pkg, ple_ram.
module ple_front #(
	parameter int MAX_SIDE  = ple_pkg::DEF_MAX_SIDE,
	parameter int SPIN_BITS = ple_pkg::DEF_SPIN_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [ple_pkg::SIDE_W-1:0]  side_length,
	input  logic                        restart,
	input  logic                        push,
	output logic                        full,
	input  logic [SPIN_BITS-1:0]        spin,
	input  logic                        q_full,
	output logic                        q_push,
	output ple_pkg::bond_t              q_entry
);
	import ple_pkg::*;

	localparam int IW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int NW = $clog2(MAX_SIDE + 1);
	localparam int CW = ((NW > SIDE_W) ? NW : SIDE_W) + 1;

	logic [IW-1:0]        row_q, col_q;
	logic [SPIN_BITS-1:0] left_q, row_start_q;

	logic                 s1_v_q;
	logic [SPIN_BITS-1:0] spin_s1;
	logic                 h_left_s1, h_wrap_s1, up_chk_s1, dn_chk_s1, dn_self_s1, last_s1;

	logic [SPIN_BITS-1:0] above_rd, first_rd;
	logic [CW-1:0]        side_ext, eff_side;
	logic                 accept, last_col, last_row, h_left, h_wrap, up_hit, dn_hit;

	assign side_ext = CW'(side_length);

	always_comb begin
		if (side_ext == '0) begin
			eff_side = CW'(1);
		end else if (side_ext > CW'(MAX_SIDE)) begin
			eff_side = CW'(MAX_SIDE);
		end else begin
			eff_side = side_ext;
		end
	end

	assign last_col = (CW'(col_q) + CW'(1)) >= eff_side;
	assign last_row = (CW'(row_q) + CW'(1)) >= eff_side;

	assign full   = s1_v_q && q_full;
	assign accept = push && !full;
	assign q_push = s1_v_q && !q_full;

	// A row of one site wraps onto itself.
	assign h_left = (col_q != '0) && (left_q == spin);
	assign h_wrap = last_col && ((col_q == '0) || (row_start_q == spin));

	ple_ram #(.WIDTH(SPIN_BITS), .DEPTH(MAX_SIDE), .AW(IW)) u_above_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (spin),
		.re    (accept),
		.raddr (col_q),
		.rdata (above_rd)
	);

	ple_ram #(.WIDTH(SPIN_BITS), .DEPTH(MAX_SIDE), .AW(IW)) u_first_ram (
		.clk   (clk),
		.we    (accept && (row_q == '0)),
		.waddr (col_q),
		.wdata (spin),
		.re    (accept),
		.raddr (col_q),
		.rdata (first_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			s1_v_q <= 1'b0;
		end else begin
			if (restart) begin
				row_q <= '0;
				col_q <= '0;
			end else if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + IW'(1);
				end else begin
					col_q <= col_q + IW'(1);
				end
			end
			if (accept) begin
				s1_v_q <= 1'b1;
			end else if (q_push) begin
				s1_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			left_q <= spin;
			if (col_q == '0) begin
				row_start_q <= spin;
			end
			spin_s1    <= spin;
			h_left_s1  <= h_left;
			h_wrap_s1  <= h_wrap;
			up_chk_s1  <= (row_q != '0);
			dn_chk_s1  <= last_row;
			dn_self_s1 <= (row_q == '0);
			last_s1    <= last_col && last_row;
		end
	end

	assign up_hit = up_chk_s1 && (above_rd == spin_s1);
	assign dn_hit = dn_chk_s1 && (dn_self_s1 || (first_rd == spin_s1));

	assign q_entry.incr = INCR_W'(h_left_s1) + INCR_W'(h_wrap_s1)
		+ INCR_W'(up_hit) + INCR_W'(dn_hit);
	assign q_entry.last = last_s1;

endmodule

### hw/rtl/ple_queue.sv
// Short queue of classified sites between front and back end.
// Uses ple_pkg for the entry type and depth.
module ple_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_en,
	input  ple_pkg::bond_t din,
	input  logic           pop_en,
	output ple_pkg::bond_t dout,
	output logic           full,
	output logic           empty
);
	import ple_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	bond_t         entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [NW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == NW'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push_en && !full;
	assign do_pop  = pop_en && !empty;
	assign dout    = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= din;
		end
	end

endmodule

### hw/rtl/ple_back.sv
// Back end: accumulates equal pairs, scales the final count by the coupling
// and holds the result for the reader. Uses ple_pkg.
module ple_back #(
	parameter int MAX_SIDE = ple_pkg::DEF_MAX_SIDE
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                restart,
	input  logic signed [ple_pkg::COUPLING_W-1:0] coupling,
	input  logic                                q_empty,
	input  ple_pkg::bond_t                      q_entry,
	output logic                                q_pop,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [ple_pkg::ENERGY_W-1:0] lattice_energy
);
	import ple_pkg::*;

	localparam int CNTW = $clog2(2 * MAX_SIDE * MAX_SIDE + 1);
	localparam int PW   = COUPLING_W + CNTW + 1;

	logic [CNTW-1:0]        cnt_q, cnt_sum, fin_cnt_s1;
	logic                   fin_v_s1, prod_v_s2, out_v_q;
	logic signed [PW-1:0]   prod_s2, mul_a, mul_b, neg, biased, shifted;
	logic                   out_ready, prod_ready, fin_ready;

	assign out_ready  = !out_v_q || pop;
	assign prod_ready = !prod_v_s2 || out_ready;
	assign fin_ready  = !fin_v_s1 || prod_ready;
	assign q_pop      = !q_empty && fin_ready;
	assign empty      = !out_v_q;

	assign cnt_sum = cnt_q + CNTW'(q_entry.incr);
	assign mul_a   = PW'(coupling);
	assign mul_b   = $signed(PW'(fin_cnt_s1));

	// Negate, then divide by 256 rounding toward zero.
	assign neg     = -prod_s2;
	assign biased  = neg[PW-1] ? neg + PW'(255) : neg;
	assign shifted = biased >>> 8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			fin_v_s1  <= 1'b0;
			prod_v_s2 <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (restart) begin
				cnt_q <= '0;
			end else if (q_pop) begin
				cnt_q <= q_entry.last ? '0 : cnt_sum;
			end
			if (fin_ready) begin
				fin_v_s1 <= q_pop && q_entry.last;
			end
			if (prod_ready) begin
				prod_v_s2 <= fin_v_s1;
			end
			if (out_ready) begin
				out_v_q <= prod_v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_ready && q_pop && q_entry.last) begin
			fin_cnt_s1 <= cnt_sum;
		end
		if (prod_ready && fin_v_s1) begin
			prod_s2 <= mul_a * mul_b;
		end
		if (out_ready && prod_v_s2) begin
			lattice_energy <= ENERGY_W'(shifted);
		end
	end

endmodule
